@@ hdl/tsd_pkg.sv @@
// Shared widths, constants and the month table for the timestamp difference block.
`timescale 1ns / 1ps

package tsd_pkg;

	// Field widths of one word.
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int DCOUNT_W = 22;

	// Internal widths: day number of a stamp, seconds within a day, remainder below an hour.
	localparam int DAYNUM_W = 23;
	localparam int TOD_W    = 17;
	localparam int REM_W    = 12;
	localparam int QUAD_W   = 12;
	localparam int CENT_W   = 8;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [TOD_W-1:0] SEC_PER_DAY = 17'd86400;

	// Multipliers and reciprocals fed to the shared multiplier.
	localparam logic [MUL_B_W-1:0] K_DAYS_PER_YEAR = 16'd365;
	localparam logic [MUL_B_W-1:0] K_RECIP_25      = 16'd5243;  // 2^17 / 25, rounded up
	localparam logic [MUL_B_W-1:0] K_SEC_PER_HOUR  = 16'd3600;
	localparam logic [MUL_B_W-1:0] K_SEC_PER_MIN   = 16'd60;
	localparam logic [MUL_B_W-1:0] K_RECIP_3600    = 16'd37283; // 2^27 / 3600, rounded up
	localparam logic [MUL_B_W-1:0] K_RECIP_60      = 16'd4370;  // 2^18 / 60, rounded up

	localparam int RECIP_25_SH   = 17;
	localparam int RECIP_3600_SH = 27;
	localparam int RECIP_60_SH   = 18;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} stamp_t;

	// Days in a common year before the first of the given month (1 to 12).
	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
		logic [8:0] days;
		case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

@@ hdl/tsd_mul.sv @@
// Shared multiplier with a registered product, used by the multiplying steps of the sequencer.
`timescale 1ns / 1ps

module tsd_mul (
	input  logic                          clk,
	input  logic [tsd_pkg::MUL_A_W-1:0]   op_a,
	input  logic [tsd_pkg::MUL_B_W-1:0]   op_b,
	output logic [tsd_pkg::PROD_W-1:0]    prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= tsd_pkg::PROD_W'(op_a) * tsd_pkg::PROD_W'(op_b);
	end

endmodule

@@ hdl/timestamp_difference.sv @@
// Top level of the timestamp difference block: sequencer, datapath and result registers.
`timescale 1ns / 1ps

// Takes two Gregorian timestamps on start and returns the distance between them as whole
// days plus hours, minutes and seconds, with order_swapped set when the second stamp comes
// first. A word is taken at an edge where start is high and busy is low; busy then stays high
// until the sequence ends, and the result shows on done for exactly one cycle after that. The
// length of the sequence is set by the single multiplier, which each of the two stamps uses four
// times and the final split into hours, minutes and seconds four more times. The receiver cannot
// stall: capture the result in the cycle that done is high. Out-of-range years and months are
// clamped, other fields are taken at face value, and a day count beyond the field saturates the
// whole result.
module timestamp_difference #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [tsd_pkg::YEAR_W-1:0]      first_year,
	input  logic [tsd_pkg::MONTH_W-1:0]     first_month,
	input  logic [tsd_pkg::DAY_W-1:0]       first_day,
	input  logic [tsd_pkg::HOUR_W-1:0]      first_hour,
	input  logic [tsd_pkg::MINUTE_W-1:0]    first_minute,
	input  logic [tsd_pkg::SECOND_W-1:0]    first_second,
	input  logic [tsd_pkg::YEAR_W-1:0]      second_year,
	input  logic [tsd_pkg::MONTH_W-1:0]     second_month,
	input  logic [tsd_pkg::DAY_W-1:0]       second_day,
	input  logic [tsd_pkg::HOUR_W-1:0]      second_hour,
	input  logic [tsd_pkg::MINUTE_W-1:0]    second_minute,
	input  logic [tsd_pkg::SECOND_W-1:0]    second_second,
	output logic                            done,
	output logic [tsd_pkg::DCOUNT_W-1:0]    day_count,
	output logic [tsd_pkg::HOUR_W-1:0]      hour_count,
	output logic [tsd_pkg::MINUTE_W-1:0]    minute_count,
	output logic [tsd_pkg::SECOND_W-1:0]    second_count,
	output logic                            order_swapped
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_YEAR = 4'd1;
	localparam logic [3:0] ST_CENT = 4'd2;
	localparam logic [3:0] ST_HOUR = 4'd3;
	localparam logic [3:0] ST_MIN  = 4'd4;
	localparam logic [3:0] ST_SEC  = 4'd5;
	localparam logic [3:0] ST_NORM = 4'd6;
	localparam logic [3:0] ST_CMP  = 4'd7;
	localparam logic [3:0] ST_SUB  = 4'd8;
	localparam logic [3:0] ST_HR   = 4'd9;
	localparam logic [3:0] ST_HRQ  = 4'd10;
	localparam logic [3:0] ST_REM  = 4'd11;
	localparam logic [3:0] ST_MN   = 4'd12;
	localparam logic [3:0] ST_MNQ  = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0] state_q;
	logic       side_q;
	logic       done_q;

	tsd_pkg::stamp_t first_q;
	tsd_pkg::stamp_t second_q;
	tsd_pkg::stamp_t cur;

	logic [tsd_pkg::DAYNUM_W-1:0] days_q;
	logic [tsd_pkg::TOD_W-1:0]    tod_q;
	logic                         leap_q;
	logic [tsd_pkg::DAYNUM_W-1:0] a_days_q;
	logic [tsd_pkg::TOD_W-1:0]    a_tod_q;
	logic [tsd_pkg::DAYNUM_W-1:0] b_days_q;
	logic [tsd_pkg::TOD_W-1:0]    b_tod_q;
	logic                         swapped_q;
	logic [tsd_pkg::DAYNUM_W-1:0] dd_q;
	logic [tsd_pkg::TOD_W-1:0]    dt_q;
	logic [tsd_pkg::HOUR_W-1:0]   hour_q;
	logic [tsd_pkg::MINUTE_W-1:0] min_q;
	logic [tsd_pkg::REM_W-1:0]    r_q;

	logic [tsd_pkg::DCOUNT_W-1:0] day_count_q;
	logic [tsd_pkg::HOUR_W-1:0]   hour_count_q;
	logic [tsd_pkg::MINUTE_W-1:0] minute_count_q;
	logic [tsd_pkg::SECOND_W-1:0] second_count_q;
	logic                         order_swapped_q;

	logic [tsd_pkg::YEAR_W-1:0]   y_c;
	logic [tsd_pkg::MONTH_W-1:0]  m_c;
	logic [tsd_pkg::YEAR_W-1:0]   p;
	logic [tsd_pkg::QUAD_W-1:0]   quads;
	logic [tsd_pkg::CENT_W-1:0]   cents;
	logic [tsd_pkg::QUAD_W-1:0]   cent_rem;
	logic                         cent_yr;
	logic                         quad_cent_yr;
	logic                         leap_d;
	logic [tsd_pkg::HOUR_W-1:0]   hr;
	logic [tsd_pkg::MINUTE_W-1:0] mn;
	logic [tsd_pkg::TOD_W-1:0]    tod_n;
	logic [tsd_pkg::DAYNUM_W-1:0] days_n;
	logic [tsd_pkg::DAYNUM_W-1:0] hi_days;
	logic [tsd_pkg::DAYNUM_W-1:0] lo_days;
	logic [tsd_pkg::TOD_W-1:0]    hi_tod;
	logic [tsd_pkg::TOD_W-1:0]    lo_tod;
	logic [tsd_pkg::TOD_W:0]      tdiff;

	logic [tsd_pkg::MUL_A_W-1:0]  op_a;
	logic [tsd_pkg::MUL_B_W-1:0]  op_b;
	logic [tsd_pkg::PROD_W-1:0]   prod_q;

	tsd_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign busy = (state_q != ST_IDLE);
	assign cur  = side_q ? second_q : first_q;

	// Year and month are clamped to the calendar before any arithmetic.
	always_comb begin
		y_c = cur.year;
		if (y_c == '0) begin
			y_c = tsd_pkg::YEAR_W'(1);
		end
		if (int'(cur.year) > MAX_YEAR) begin
			y_c = tsd_pkg::YEAR_W'(MAX_YEAR);
		end
		m_c = cur.month;
		if (m_c == '0) begin
			m_c = tsd_pkg::MONTH_W'(1);
		end
		if (m_c > tsd_pkg::MONTH_W'(12)) begin
			m_c = tsd_pkg::MONTH_W'(12);
		end
	end

	assign p     = y_c - tsd_pkg::YEAR_W'(1);
	assign quads = p[tsd_pkg::YEAR_W-1:2];
	assign cents = prod_q[tsd_pkg::RECIP_25_SH +: tsd_pkg::CENT_W];

	// The year is a century year when quads + 1 is a multiple of 25, and a
	// fourth century when the century number cents + 1 is a multiple of four.
	assign cent_rem     = tsd_pkg::QUAD_W'(quads - tsd_pkg::QUAD_W'(cents) * tsd_pkg::QUAD_W'(25));
	assign cent_yr      = (y_c[1:0] == 2'b00) && (cent_rem == tsd_pkg::QUAD_W'(24));
	assign quad_cent_yr = cent_yr && (cents[1:0] == 2'b11);
	assign leap_d       = (y_c[1:0] == 2'b00) && (!cent_yr || quad_cent_yr);

	assign hr = prod_q[tsd_pkg::RECIP_3600_SH +: tsd_pkg::HOUR_W];
	assign mn = prod_q[tsd_pkg::RECIP_60_SH +: tsd_pkg::MINUTE_W];

	// Seconds past midnight may exceed one day when fields run past their range.
	always_comb begin
		tod_n  = tod_q;
		days_n = days_q;
		if (tod_q >= tsd_pkg::SEC_PER_DAY) begin
			tod_n  = tod_q - tsd_pkg::SEC_PER_DAY;
			days_n = days_q + tsd_pkg::DAYNUM_W'(1);
		end
	end

	assign hi_days = swapped_q ? a_days_q : b_days_q;
	assign lo_days = swapped_q ? b_days_q : a_days_q;
	assign hi_tod  = swapped_q ? a_tod_q : b_tod_q;
	assign lo_tod  = swapped_q ? b_tod_q : a_tod_q;
	assign tdiff   = {1'b0, hi_tod} - {1'b0, lo_tod};

	always_comb begin
		case (state_q)
			ST_YEAR: begin
				op_a = tsd_pkg::MUL_A_W'(p);
				op_b = tsd_pkg::K_DAYS_PER_YEAR;
			end
			ST_CENT: begin
				op_a = tsd_pkg::MUL_A_W'(quads);
				op_b = tsd_pkg::K_RECIP_25;
			end
			ST_HOUR: begin
				op_a = tsd_pkg::MUL_A_W'(cur.hour);
				op_b = tsd_pkg::K_SEC_PER_HOUR;
			end
			ST_MIN: begin
				op_a = tsd_pkg::MUL_A_W'(cur.minute);
				op_b = tsd_pkg::K_SEC_PER_MIN;
			end
			ST_HR: begin
				op_a = dt_q;
				op_b = tsd_pkg::K_RECIP_3600;
			end
			ST_HRQ: begin
				op_a = tsd_pkg::MUL_A_W'(hr);
				op_b = tsd_pkg::K_SEC_PER_HOUR;
			end
			ST_MN: begin
				op_a = tsd_pkg::MUL_A_W'(r_q);
				op_b = tsd_pkg::K_RECIP_60;
			end
			ST_MNQ: begin
				op_a = tsd_pkg::MUL_A_W'(mn);
				op_b = tsd_pkg::K_SEC_PER_MIN;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					side_q <= 1'b0;
					if (start) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: state_q <= ST_CENT;
				ST_CENT: state_q <= ST_HOUR;
				ST_HOUR: state_q <= ST_MIN;
				ST_MIN:  state_q <= ST_SEC;
				ST_SEC:  state_q <= ST_NORM;
				ST_NORM: begin
					if (side_q) begin
						state_q <= ST_CMP;
					end else begin
						side_q  <= 1'b1;
						state_q <= ST_YEAR;
					end
				end
				ST_CMP:  state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_HR;
				ST_HR:   state_q <= ST_HRQ;
				ST_HRQ:  state_q <= ST_REM;
				ST_REM:  state_q <= ST_MN;
				ST_MN:   state_q <= ST_MNQ;
				ST_MNQ:  state_q <= ST_OUT;
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			first_q  <= '{first_year, first_month, first_day,
				first_hour, first_minute, first_second};
			second_q <= '{second_year, second_month, second_day,
				second_hour, second_minute, second_second};
		end
		case (state_q)
			ST_CENT: begin
				days_q <= prod_q[tsd_pkg::DAYNUM_W-1:0];
			end
			ST_HOUR: begin
				days_q <= days_q + tsd_pkg::DAYNUM_W'(quads) - tsd_pkg::DAYNUM_W'(cents)
					+ tsd_pkg::DAYNUM_W'(cents[tsd_pkg::CENT_W-1:2]);
				leap_q <= leap_d;
			end
			ST_MIN: begin
				tod_q  <= prod_q[tsd_pkg::TOD_W-1:0];
				days_q <= days_q + tsd_pkg::DAYNUM_W'(tsd_pkg::month_start(m_c))
					+ tsd_pkg::DAYNUM_W'(leap_q && (m_c > tsd_pkg::MONTH_W'(2)))
					+ tsd_pkg::DAYNUM_W'(cur.day);
			end
			ST_SEC: begin
				tod_q <= tod_q + tsd_pkg::TOD_W'(prod_q[tsd_pkg::REM_W-1:0])
					+ tsd_pkg::TOD_W'(cur.second);
			end
			ST_NORM: begin
				if (side_q) begin
					b_days_q <= days_n;
					b_tod_q  <= tod_n;
				end else begin
					a_days_q <= days_n;
					a_tod_q  <= tod_n;
				end
			end
			ST_CMP: begin
				swapped_q <= (b_days_q < a_days_q) ||
					((b_days_q == a_days_q) && (b_tod_q < a_tod_q));
			end
			ST_SUB: begin
				// Borrow one day when the later stamp is earlier in its day.
				if (tdiff[tsd_pkg::TOD_W]) begin
					dt_q <= tsd_pkg::TOD_W'(tdiff + (tsd_pkg::TOD_W+1)'(tsd_pkg::SEC_PER_DAY));
					dd_q <= hi_days - lo_days - tsd_pkg::DAYNUM_W'(1);
				end else begin
					dt_q <= tdiff[tsd_pkg::TOD_W-1:0];
					dd_q <= hi_days - lo_days;
				end
			end
			ST_HRQ: begin
				hour_q <= hr;
			end
			ST_REM: begin
				r_q <= tsd_pkg::REM_W'(dt_q - prod_q[tsd_pkg::TOD_W-1:0]);
			end
			ST_MNQ: begin
				min_q <= mn;
			end
			ST_OUT: begin
				order_swapped_q <= swapped_q;
				if (dd_q[tsd_pkg::DAYNUM_W-1]) begin
					day_count_q    <= '1;
					hour_count_q   <= tsd_pkg::HOUR_W'(23);
					minute_count_q <= tsd_pkg::MINUTE_W'(59);
					second_count_q <= tsd_pkg::SECOND_W'(59);
				end else begin
					day_count_q    <= dd_q[tsd_pkg::DCOUNT_W-1:0];
					hour_count_q   <= hour_q;
					minute_count_q <= min_q;
					second_count_q <= tsd_pkg::SECOND_W'(r_q - prod_q[tsd_pkg::REM_W-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	assign done          = done_q;
	assign day_count     = day_count_q;
	assign hour_count    = hour_count_q;
	assign minute_count  = minute_count_q;
	assign second_count  = second_count_q;
	assign order_swapped = order_swapped_q;

`ifndef SYNTHESIS
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_OUT))
		else $error("done without a finished word");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && (state_q == ST_YEAR) && !side_q))
		else $error("accepted word did not start the sequence");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((hour_count < tsd_pkg::HOUR_W'(24)) && (minute_count < tsd_pkg::MINUTE_W'(60))
			&& (second_count < tsd_pkg::SECOND_W'(60))))
		else $error("result fields out of range");

	a_second_side: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> side_q)
		else $error("compare reached before both stamps were reduced");
`endif

endmodule

@@ dv/timestamp_difference_checker.sv @@
// Checker for the timestamp difference block: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module timestamp_difference_checker #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  tsd_pkg::stamp_t                 first_stamp,
	input  tsd_pkg::stamp_t                 second_stamp,
	input  logic                            done,
	input  logic [tsd_pkg::DCOUNT_W-1:0]    day_count,
	input  logic [tsd_pkg::HOUR_W-1:0]      hour_count,
	input  logic [tsd_pkg::MINUTE_W-1:0]    minute_count,
	input  logic [tsd_pkg::SECOND_W-1:0]    second_count,
	input  logic                            order_swapped,
	output int                              outstanding,
	output int                              fail_count,
	output int                              checked_count,
	output int                              swapped_count
);

	localparam longint unsigned SECS_PER_DAY = 86400;
	localparam longint unsigned DAY_COUNT_MAX = (64'd1 << tsd_pkg::DCOUNT_W) - 64'd1;

	typedef struct packed {
		logic [tsd_pkg::DCOUNT_W-1:0] days;
		logic [tsd_pkg::HOUR_W-1:0]   hours;
		logic [tsd_pkg::MINUTE_W-1:0] minutes;
		logic [tsd_pkg::SECOND_W-1:0] seconds;
		logic                         swapped;
	} difference_t;

	difference_t pending_diffs[$];
	int mismatches = 0;
	int checked = 0;
	int swapped_seen = 0;

	// Seconds since a fixed epoch, with year and month clamped and the other fields at face value.
	function automatic longint unsigned stamp_to_seconds(tsd_pkg::stamp_t st);
		longint unsigned yr;
		longint unsigned mo;
		longint unsigned prior;
		longint unsigned days;
		bit leap;
		int m;
		yr = 64'(st.year);
		mo = 64'(st.month);
		if (yr < 64'd1) yr = 64'd1;
		if (yr > 64'(MAX_YEAR)) yr = 64'(MAX_YEAR);
		if (mo < 64'd1) mo = 64'd1;
		if (mo > 64'd12) mo = 64'd12;
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		prior = yr - 64'd1;
		days = prior * 365 + prior / 4 - prior / 100 + prior / 400;
		for (m = 1; m < int'(mo); m++) begin
			case (m)
				2:         days += leap ? 64'd29 : 64'd28;
				4, 6, 9, 11: days += 64'd30;
				default:   days += 64'd31;
			endcase
		end
		days += 64'(st.day);
		return ((days * 24 + 64'(st.hour)) * 60 + 64'(st.minute)) * 60 + 64'(st.second);
	endfunction

	function automatic difference_t predict_difference(tsd_pkg::stamp_t a, tsd_pkg::stamp_t b);
		longint unsigned secs_a;
		longint unsigned secs_b;
		longint unsigned span;
		longint unsigned whole_days;
		difference_t d;
		secs_a = stamp_to_seconds(a);
		secs_b = stamp_to_seconds(b);
		d.swapped = secs_b < secs_a;
		span = d.swapped ? secs_a - secs_b : secs_b - secs_a;
		whole_days = span / SECS_PER_DAY;
		if (whole_days > DAY_COUNT_MAX) begin
			d.days = '1;
			d.hours = tsd_pkg::HOUR_W'(23);
			d.minutes = tsd_pkg::MINUTE_W'(59);
			d.seconds = tsd_pkg::SECOND_W'(59);
		end else begin
			d.days = tsd_pkg::DCOUNT_W'(whole_days);
			d.hours = tsd_pkg::HOUR_W'((span / 3600) % 24);
			d.minutes = tsd_pkg::MINUTE_W'((span / 60) % 60);
			d.seconds = tsd_pkg::SECOND_W'(span % 60);
		end
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		difference_t want;
		if (arst_n) begin
			// A result may come at the same edge as the next word is taken; it belongs to the older one.
			if (done) begin
				if (pending_diffs.size() == 0) begin
					report_mismatch("unexpected result word", 64'(day_count), 64'd0);
				end else begin
					want = pending_diffs.pop_front();
					checked++;
					if (order_swapped === 1'b1) swapped_seen++;
					if (day_count !== want.days)
						report_mismatch("day_count", 64'(day_count), 64'(want.days));
					if (hour_count !== want.hours)
						report_mismatch("hour_count", 64'(hour_count), 64'(want.hours));
					if (minute_count !== want.minutes)
						report_mismatch("minute_count", 64'(minute_count),
							64'(want.minutes));
					if (second_count !== want.seconds)
						report_mismatch("second_count", 64'(second_count),
							64'(want.seconds));
					if (order_swapped !== want.swapped)
						report_mismatch("order_swapped", 64'(order_swapped),
							64'(want.swapped));
				end
			end
			if (start && !busy)
				pending_diffs.push_back(predict_difference(first_stamp, second_stamp));
		end
		outstanding <= pending_diffs.size();
		fail_count <= mismatches;
		checked_count <= checked;
		swapped_count <= swapped_seen;
	end

endmodule

@@ dv/timestamp_difference_tb.sv @@
// Testbench top for the timestamp difference block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module timestamp_difference_tb;

	localparam int RANDOM_WORDS = 1350;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 30;
	localparam int STAMP_W = $bits(tsd_pkg::stamp_t);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tsd_pkg::stamp_t first_stamp;
	tsd_pkg::stamp_t second_stamp;
	logic done;
	logic [tsd_pkg::DCOUNT_W-1:0] day_count;
	logic [tsd_pkg::HOUR_W-1:0] hour_count;
	logic [tsd_pkg::MINUTE_W-1:0] minute_count;
	logic [tsd_pkg::SECOND_W-1:0] second_count;
	logic order_swapped;

	int outstanding;
	int fail_count;
	int checked_count;
	int swapped_count;
	int quiet_cycles = 0;

	timestamp_difference dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_year(first_stamp.year),
		.first_month(first_stamp.month),
		.first_day(first_stamp.day),
		.first_hour(first_stamp.hour),
		.first_minute(first_stamp.minute),
		.first_second(first_stamp.second),
		.second_year(second_stamp.year),
		.second_month(second_stamp.month),
		.second_day(second_stamp.day),
		.second_hour(second_stamp.hour),
		.second_minute(second_stamp.minute),
		.second_second(second_stamp.second),
		.done(done),
		.day_count(day_count),
		.hour_count(hour_count),
		.minute_count(minute_count),
		.second_count(second_count),
		.order_swapped(order_swapped)
	);

	timestamp_difference_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_stamp(first_stamp),
		.second_stamp(second_stamp),
		.done(done),
		.day_count(day_count),
		.hour_count(hour_count),
		.minute_count(minute_count),
		.second_count(second_count),
		.order_swapped(order_swapped),
		.outstanding(outstanding),
		.fail_count(fail_count),
		.checked_count(checked_count),
		.swapped_count(swapped_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ends the run when neither a word is taken nor a result shows for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("timestamp_difference_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tsd_pkg::stamp_t make_stamp(int yr, int mo, int dy, int hr, int mi,
			int se);
		tsd_pkg::stamp_t st;
		st.year = tsd_pkg::YEAR_W'(yr);
		st.month = tsd_pkg::MONTH_W'(mo);
		st.day = tsd_pkg::DAY_W'(dy);
		st.hour = tsd_pkg::HOUR_W'(hr);
		st.minute = tsd_pkg::MINUTE_W'(mi);
		st.second = tsd_pkg::SECOND_W'(se);
		return st;
	endfunction

	function automatic tsd_pkg::stamp_t valid_stamp();
		tsd_pkg::stamp_t st;
		st.year = tsd_pkg::YEAR_W'($urandom_range(9999, 1));
		st.month = tsd_pkg::MONTH_W'($urandom_range(12, 1));
		st.day = tsd_pkg::DAY_W'(($urandom_range(3) == 0) ? $urandom_range(31, 1)
			: $urandom_range(28, 1));
		st.hour = tsd_pkg::HOUR_W'($urandom_range(23, 0));
		st.minute = tsd_pkg::MINUTE_W'($urandom_range(59, 0));
		st.second = tsd_pkg::SECOND_W'($urandom_range(59, 0));
		return st;
	endfunction

	// Redraws some fields of a stamp so the pair lands close together and borrows often.
	function automatic tsd_pkg::stamp_t nearby_stamp(tsd_pkg::stamp_t base);
		tsd_pkg::stamp_t st;
		st = base;
		if ($urandom_range(3) == 0) begin
			st.year = tsd_pkg::YEAR_W'(int'(base.year) + int'($urandom_range(2)) - 1);
			if (st.year == 0 || st.year > 9999) st.year = base.year;
		end
		if ($urandom_range(2) == 0) st.month = tsd_pkg::MONTH_W'($urandom_range(12, 1));
		if ($urandom_range(2) == 0) st.day = tsd_pkg::DAY_W'($urandom_range(31, 1));
		if ($urandom_range(1) == 0) st.hour = tsd_pkg::HOUR_W'($urandom_range(23, 0));
		if ($urandom_range(1) == 0) st.minute = tsd_pkg::MINUTE_W'($urandom_range(59, 0));
		if ($urandom_range(1) == 0) st.second = tsd_pkg::SECOND_W'($urandom_range(59, 0));
		return st;
	endfunction

	// Holds the word steady and raises start in a given share of cycles until it is taken.
	task automatic send_pair(tsd_pkg::stamp_t a, tsd_pkg::stamp_t b, int idle_pct);
		first_stamp <= a;
		second_stamp <= b;
		do begin
			start <= (int'($urandom_range(99)) >= idle_pct);
			@(posedge clk);
		end while (!(start && !busy));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		tsd_pkg::stamp_t a;
		tsd_pkg::stamp_t b;
		int phase;
		int n;
		int idle_pct;
		int kind;

		arst_n <= 1'b0;
		start <= 1'b0;
		first_stamp <= '0;
		second_stamp <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, leap years, clamped and out-of-range fields, borrows and order.
		send_pair(make_stamp(1, 1, 1, 0, 0, 0), make_stamp(1, 1, 1, 0, 0, 0), 0);
		send_pair(make_stamp(1, 1, 1, 0, 0, 0), make_stamp(9999, 12, 31, 23, 59, 59), 0);
		send_pair(make_stamp(9999, 12, 31, 23, 59, 59), make_stamp(1, 1, 1, 0, 0, 0), 0);
		send_pair('0, '1, 0);
		send_pair('1, '0, 0);
		send_pair(make_stamp(2000, 2, 28, 12, 0, 0), make_stamp(2000, 3, 1, 12, 0, 0), 0);
		send_pair(make_stamp(1900, 2, 28, 12, 0, 0), make_stamp(1900, 3, 1, 12, 0, 0), 0);
		send_pair(make_stamp(2004, 2, 28, 6, 30, 0), make_stamp(2004, 3, 1, 6, 30, 0), 0);
		send_pair(make_stamp(2001, 3, 1, 6, 30, 0), make_stamp(2001, 2, 28, 6, 30, 0), 0);
		send_pair(make_stamp(2023, 5, 10, 23, 59, 59), make_stamp(2023, 5, 11, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 5, 11, 0, 0, 0), make_stamp(2023, 5, 10, 23, 59, 59), 0);
		send_pair(make_stamp(1999, 12, 31, 23, 59, 59), make_stamp(2000, 1, 1, 0, 0, 0), 0);
		send_pair(make_stamp(1600, 1, 1, 0, 0, 0), make_stamp(2000, 1, 1, 0, 0, 0), 0);
		send_pair(make_stamp(0, 6, 15, 8, 0, 0), make_stamp(1, 6, 15, 8, 0, 0), 0);
		send_pair(make_stamp(10000, 6, 15, 8, 0, 0), make_stamp(9999, 6, 15, 8, 0, 0), 0);
		send_pair(make_stamp(2023, 0, 5, 0, 0, 0), make_stamp(2023, 1, 5, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 13, 5, 0, 0, 0), make_stamp(2023, 12, 5, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 3, 0, 0, 0, 0), make_stamp(2023, 2, 28, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 2, 31, 0, 0, 0), make_stamp(2023, 3, 3, 0, 0, 0), 0);
		send_pair(make_stamp(2024, 2, 31, 0, 0, 0), make_stamp(2024, 3, 2, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 7, 4, 24, 0, 0), make_stamp(2023, 7, 5, 0, 0, 0), 0);
		send_pair(make_stamp(2023, 7, 4, 10, 60, 60), make_stamp(2023, 7, 4, 11, 1, 0), 0);
		send_pair(make_stamp(2023, 7, 4, 31, 63, 63), make_stamp(2023, 7, 4, 0, 0, 0), 0);
		send_pair(make_stamp(5000, 6, 30, 0, 0, 1), make_stamp(5000, 6, 30, 0, 0, 0), 0);
		wait_for_results();

		// Three phases: no idling, heavy sender idling, light sender idling.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 71 : 13;
			for (n = 0; n < RANDOM_WORDS / 3; n++) begin
				kind = int'($urandom_range(99));
				if (kind < 40) begin
					a = valid_stamp();
					b = valid_stamp();
				end else if (kind < 75) begin
					a = valid_stamp();
					b = nearby_stamp(a);
				end else if (kind < 85) begin
					a = valid_stamp();
					b = a;
					if ($urandom_range(1) == 0)
						b.second = a.second ^ tsd_pkg::SECOND_W'(1);
				end else begin
					a = STAMP_W'($urandom);
					b = STAMP_W'({$urandom, $urandom});
				end
				if ($urandom_range(1) == 0)
					send_pair(a, b, idle_pct);
				else
					send_pair(b, a, idle_pct);
			end
			wait_for_results();
		end

		$display("checked %0d timestamp differences, %0d of them with the stamps in reverse order",
			checked_count, swapped_count);
		$display("random words ran with start held high, low in most cycles, low in a few cycles");
		if (fail_count == 0 && outstanding == 0) begin
			$display("timestamp_difference_tb OK");
		end else begin
			$display("%0d mismatches, %0d results never came", fail_count, outstanding);
			$display("timestamp_difference_tb NOT OK");
		end
		$finish;
	end

endmodule
